// ----- rtl/mode_frequency_table_top_macros.svh -----
// Assertion macros shared by the mode frequency table RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef MODE_FREQUENCY_TABLE_TOP_MACROS_SVH
`define MODE_FREQUENCY_TABLE_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define MFT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/mft_pkg.sv -----
// Package for the mode frequency table: field widths, defaults and the probe control struct.
// No dependencies; imported by mft_cell and mode_frequency_table_top.
package mft_pkg;

  localparam int KEY_FIELD_W   = 64;
  localparam int ADD_FIELD_W   = 32;
  localparam int COUNT_FIELD_W = 48;
  localparam int DISTINCT_W    = 7;
  localparam int IN_DATA_W     = 96;   // key_bits, add_count
  localparam int OUT_DATA_W    = 120;  // mode_key, mode_count, distinct_keys, pad
  localparam int OUT_USER_W    = 2;    // has_mode, dropped_full

  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int DEF_KEY_WIDTH     = 64;
  localparam int DEF_COUNT_WIDTH   = 48;

  // Control bits of the probe that walks down the row of cells.
  typedef struct packed {
    logic vld;   // a probe is present at this position
    logic done;  // an earlier cell already hit or inserted the key
    logic ins;   // the key was inserted into a free entry
  } tok_ctl_t;

endpackage

// ----- rtl/mode_frequency_table_top.sv -----
// Mode frequency table: a row of TABLE_ENTRIES cells that a probe walks one cell a cycle.
// A result passes the head register, each cell register and the output register.
// One item at a time: a new item waits until the previous probe has left the last cell.
// A new item is taken once the previous result is delivered or in its delivery cycle.
// Reset (synchronous, rst_n low) clears all valid bits, the mode and the distinct count.
// A group-start item clears the table in the cycle of its transfer.
module mode_frequency_table_top
  import mft_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int KEY_WIDTH     = DEF_KEY_WIDTH,
  parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key_bits[63:0], add_count[95:64]
  input  logic                  in_tuser,   // group_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // mode_key[63:0], mode_count[111:64],
                                            // distinct_keys[118:112], zero[119]
  output logic [OUT_USER_W-1:0] out_tuser   // has_mode[0], dropped_full[1]
);

  `include "mode_frequency_table_top_macros.svh"

  localparam int UW = $clog2(TABLE_ENTRIES + 1);

  tok_ctl_t               ctl_w [0:TABLE_ENTRIES];
  logic [KEY_WIDTH-1:0]   key_w [0:TABLE_ENTRIES];
  logic [ADD_FIELD_W-1:0] add_w [0:TABLE_ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_w [0:TABLE_ENTRIES];

  logic                   acc;
  logic                   busy_r, busy_nxt;
  tok_ctl_t               head_ctl_r, head_ctl_nxt;
  logic [KEY_WIDTH-1:0]   head_key_r;
  logic [ADD_FIELD_W-1:0] head_add_r;

  logic [KEY_WIDTH-1:0]   best_key_r, best_key_nxt;
  logic [COUNT_WIDTH-1:0] best_cnt_r, best_cnt_nxt;
  logic [UW-1:0]          used_r, used_nxt;
  logic                   dropped;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]  out_tdata_r;
  logic [OUT_USER_W-1:0]  out_tuser_r;
  logic [63:0]            key_wide, cnt_wide, used_wide;
  logic                   has_mode;

  assign in_tready = !busy_r && (!out_tvalid_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    head_ctl_nxt      = '0;
    head_ctl_nxt.vld  = acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_ctl_r <= '0;
    end else begin
      head_ctl_r <= head_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      head_key_r <= in_tdata[KEY_WIDTH-1:0];
      head_add_r <= in_tdata[KEY_FIELD_W +: ADD_FIELD_W];
    end
  end

  assign ctl_w[0] = head_ctl_r;
  assign key_w[0] = head_key_r;
  assign add_w[0] = head_add_r;
  assign cnt_w[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    mft_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .clr   (acc && in_tuser),
      .ctl_i (ctl_w[i]),
      .key_i (key_w[i]),
      .add_i (add_w[i]),
      .cnt_i (cnt_w[i]),
      .ctl_o (ctl_w[i+1]),
      .key_o (key_w[i+1]),
      .add_o (add_w[i+1]),
      .cnt_o (cnt_w[i+1])
    );
  end

  // The probe leaving the last cell settles the mode and the distinct count.
  always_comb begin
    best_key_nxt = best_key_r;
    best_cnt_nxt = best_cnt_r;
    used_nxt     = used_r;
    dropped      = 1'b0;
    if (ctl_w[TABLE_ENTRIES].vld) begin
      if (ctl_w[TABLE_ENTRIES].done) begin
        if (ctl_w[TABLE_ENTRIES].ins) begin
          used_nxt = UW'(used_r + 1'b1);
        end
        // The first key of a group becomes the mode even with a zero count; ties keep it.
        if ((ctl_w[TABLE_ENTRIES].ins && (used_r == '0)) ||
            (cnt_w[TABLE_ENTRIES] > best_cnt_r)) begin
          best_key_nxt = key_w[TABLE_ENTRIES];
          best_cnt_nxt = cnt_w[TABLE_ENTRIES];
        end
      end else begin
        dropped = 1'b1;
      end
    end
    if (acc && in_tuser) begin
      best_key_nxt = '0;
      best_cnt_nxt = '0;
      used_nxt     = '0;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (acc) begin
      busy_nxt = 1'b1;
    end else if (ctl_w[TABLE_ENTRIES].vld) begin
      busy_nxt = 1'b0;
    end
    out_tvalid_nxt = out_tvalid_r;
    if (ctl_w[TABLE_ENTRIES].vld) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      best_key_r   <= '0;
      best_cnt_r   <= '0;
      used_r       <= '0;
    end else begin
      busy_r       <= busy_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      best_key_r   <= best_key_nxt;
      best_cnt_r   <= best_cnt_nxt;
      used_r       <= used_nxt;
    end
  end

  assign has_mode  = (used_nxt != '0);
  assign key_wide  = has_mode ? 64'(best_key_nxt) : 64'd0;
  assign cnt_wide  = has_mode ? 64'(best_cnt_nxt) : 64'd0;
  assign used_wide = 64'(used_nxt);

  always_ff @(posedge clk) begin
    if (ctl_w[TABLE_ENTRIES].vld) begin
      out_tdata_r <= {1'b0, used_wide[DISTINCT_W-1:0], cnt_wide[COUNT_FIELD_W-1:0],
                      key_wide[KEY_FIELD_W-1:0]};
      out_tuser_r <= {dropped, has_mode};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `MFT_ASSERT(a_accept_busy, (in_tvalid && in_tready) |=> !in_tready, "input taken while busy")
  `MFT_ASSERT(a_tail_result, ctl_w[TABLE_ENTRIES].vld |=> out_tvalid_r, "result not posted")
  `MFT_NEVER(a_used_bound, used_r > UW'(TABLE_ENTRIES), "distinct count above table size")
  `MFT_NEVER(a_tail_idle, ctl_w[TABLE_ENTRIES].vld && !busy_r, "probe finished while idle")

endmodule

// ----- rtl/mft_cell.sv -----
// One table entry of the mode frequency table: key, saturating count and valid bit.
// Depends on mft_pkg; instantiated in a row by mode_frequency_table_top.
module mft_cell
  import mft_pkg::*;
#(
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clr,
  input  tok_ctl_t               ctl_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [ADD_FIELD_W-1:0] add_i,
  input  logic [COUNT_WIDTH-1:0] cnt_i,
  output tok_ctl_t               ctl_o,
  output logic [KEY_WIDTH-1:0]   key_o,
  output logic [ADD_FIELD_W-1:0] add_o,
  output logic [COUNT_WIDTH-1:0] cnt_o
);

  localparam int SUM_W = ((COUNT_WIDTH > ADD_FIELD_W) ? COUNT_WIDTH : ADD_FIELD_W) + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   vld_r, vld_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  tok_ctl_t               ctl_r, ctl_nxt;
  logic [KEY_WIDTH-1:0]   key_o_r;
  logic [ADD_FIELD_W-1:0] add_o_r;
  logic [COUNT_WIDTH-1:0] cnt_o_r, cnt_o_nxt;

  logic                   hit;
  logic [SUM_W-1:0]       sum;
  logic [COUNT_WIDTH-1:0] sat;

  assign hit = vld_r && (key_r == key_i);
  // A free entry starts from zero, so the same adder serves hit and insert.
  assign sum = SUM_W'(hit ? cnt_r : '0) + SUM_W'(add_i);
  assign sat = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sum[COUNT_WIDTH-1:0];

  always_comb begin
    vld_nxt   = vld_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    ctl_nxt   = ctl_i;
    cnt_o_nxt = cnt_i;
    if (ctl_i.vld && !ctl_i.done) begin
      if (hit) begin
        cnt_nxt      = sat;
        ctl_nxt.done = 1'b1;
        ctl_nxt.ins  = 1'b0;
        cnt_o_nxt    = sat;
      end else if (!vld_r) begin
        // Entries fill from the head, so the first free cell is the lowest free one.
        vld_nxt      = 1'b1;
        key_nxt      = key_i;
        cnt_nxt      = sat;
        ctl_nxt.done = 1'b1;
        ctl_nxt.ins  = 1'b1;
        cnt_o_nxt    = sat;
      end
    end
    if (clr) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      ctl_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    cnt_r   <= cnt_nxt;
    key_o_r <= key_i;
    add_o_r <= add_i;
    cnt_o_r <= cnt_o_nxt;
  end

  assign ctl_o = ctl_r;
  assign key_o = key_o_r;
  assign add_o = add_o_r;
  assign cnt_o = cnt_o_r;

endmodule
